// File: rtl/core/sharded_size_class_free_list_pool_macros.svh
// Assertion macros shared by the free-list pool RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef SHARDED_SIZE_CLASS_FREE_LIST_POOL_MACROS_SVH
`define SHARDED_SIZE_CLASS_FREE_LIST_POOL_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SSCFL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sscfl: same-cycle check failed");
// next-cycle implication
`define SSCFL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sscfl: next-cycle check failed");
`else
`define SSCFL_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SSCFL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/sscfl_pkg.sv
// Shared constants, types and helper functions of the free-list pool.
// No dependencies; imported by every module of the block except sscfl_ram.
package sscfl_pkg;

    localparam int NUM_SHARDS       = 8;
    localparam int NUM_SIZE_CLASSES = 16;
    localparam int NUM_OBJECTS      = 4096;
    localparam int MAX_BATCH        = 32;

    localparam int NBINS = NUM_SHARDS * NUM_SIZE_CLASSES;
    localparam int BIN_W = (NBINS > 1) ? $clog2(NBINS) : 1;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int SHARD_W  = 3;
    localparam int CLASS_W  = 4;
    localparam int HANDLE_W = 12;
    localparam int COUNT_W  = 13;
    localparam int WANT_W   = 6;
    localparam int BATCH_W  = 6;

    localparam int LINK_DEPTH = (NUM_OBJECTS < (1 << HANDLE_W)) ? NUM_OBJECTS : (1 << HANDLE_W);
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    localparam int GOT_W      = $clog2(MAX_BATCH + 1);
    localparam int BUF_W      = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 32;

    // successor value that terminates a chain, and the count ceiling
    localparam logic [COUNT_W-1:0] END_LINK  = COUNT_W'(NUM_OBJECTS);
    localparam logic [COUNT_W-1:0] TALLY_MAX = COUNT_W'(NUM_OBJECTS);

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_CHAIN = 3'd1;
    localparam logic [OP_W-1:0] OP_POP   = 3'd2;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd3;
    localparam logic [OP_W-1:0] OP_LINK  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BIN,
        ST_POP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SHARD_W-1:0]  shard;
        logic [CLASS_W-1:0]  size_class;
        logic [HANDLE_W-1:0] first_handle;
        logic [HANDLE_W-1:0] last_handle;
        logic [COUNT_W-1:0]  chain_len;
        logic [WANT_W-1:0]   want;
        logic [COUNT_W-1:0]  link_value;
    } item_t;

    // bin table access, one read and one write port
    typedef struct packed {
        logic                rd_en;
        logic [BIN_W-1:0]    rd_addr;
        logic                wr_en;
        logic [BIN_W-1:0]    wr_addr;
        logic [HANDLE_W-1:0] wr_head;
        logic [COUNT_W-1:0]  wr_tally;
        logic                wr_nonempty;
    } bin_req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] head;
        logic [COUNT_W-1:0]  tally;
        logic                nonempty;
    } bin_rsp_t;

    // link store access
    typedef struct packed {
        logic               rd_en;
        logic [LINK_AW-1:0] rd_addr;
        logic               wr_en;
        logic [LINK_AW-1:0] wr_addr;
        logic [COUNT_W-1:0] wr_data;
    } link_req_t;

    function automatic logic handle_ok(input logic [HANDLE_W-1:0] h);
        return int'(h) < NUM_OBJECTS;
    endfunction

    function automatic logic link_end(input logic [COUNT_W-1:0] v);
        return int'(v) >= NUM_OBJECTS;
    endfunction

    function automatic logic bin_sel_ok(input logic [SHARD_W-1:0] sh,
                                        input logic [CLASS_W-1:0] sc);
        return (int'(sh) < NUM_SHARDS) && (int'(sc) < NUM_SIZE_CLASSES);
    endfunction

    function automatic logic [BIN_W-1:0] bin_index(input logic [SHARD_W-1:0] sh,
                                                   input logic [CLASS_W-1:0] sc);
        return BIN_W'(int'(sh) * NUM_SIZE_CLASSES + int'(sc));
    endfunction

    function automatic logic [COUNT_W-1:0] add_sat(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (int'(s) > NUM_OBJECTS) ? TALLY_MAX : s[COUNT_W-1:0];
    endfunction

endpackage

// File: rtl/core/sscfl_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies; holds the bin table and the link store.
module sscfl_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/sscfl_bin_table.sv
// Per-bin state: head and count in RAM, non-empty and written marks in flops.
// Depends on sscfl_pkg and sscfl_ram.
module sscfl_bin_table
    import sscfl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  bin_req_t req,
    output bin_rsp_t rsp
);

    logic [NBINS-1:0] nonempty_reg;
    logic [NBINS-1:0] written_reg;
    logic             ne_q_reg;
    logic             wr_q_reg;
    logic [HANDLE_W+COUNT_W-1:0] ram_rdata;

    // head and tally packed into one word
    sscfl_ram #(
        .DEPTH (NBINS),
        .WIDTH (HANDLE_W + COUNT_W)
    ) u_bin_ram (
        .aclk  (aclk),
        .we    (req.wr_en),
        .waddr (req.wr_addr),
        .wdata ({req.wr_head, req.wr_tally}),
        .re    (req.rd_en),
        .raddr (req.rd_addr),
        .rdata (ram_rdata)
    );

    // marks cleared at reset; an unwritten bin reads a zero count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_reg <= '0;
            written_reg  <= '0;
        end else if (req.wr_en) begin
            nonempty_reg[req.wr_addr] <= req.wr_nonempty;
            written_reg[req.wr_addr]  <= 1'b1;
        end
    end

    // marks read alongside the RAM word
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            ne_q_reg <= nonempty_reg[req.rd_addr];
            wr_q_reg <= written_reg[req.rd_addr];
        end
    end

    assign rsp.head     = ram_rdata[HANDLE_W+COUNT_W-1:COUNT_W];
    assign rsp.tally    = wr_q_reg ? ram_rdata[COUNT_W-1:0] : '0;
    assign rsp.nonempty = ne_q_reg;

endmodule

// File: rtl/core/sscfl_seq.sv
// Operation sequencer: bin read-modify-write, link walk, pop buffer, result register.
// Depends on sscfl_pkg and the assertion macro header.
`include "sharded_size_class_free_list_pool_macros.svh"

module sscfl_seq
    import sscfl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // request side
    input  logic                s_tvalid,
    output logic                s_tready,
    input  item_t               s_item,
    // result side
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [HANDLE_W-1:0] m_popped_handle,
    output logic                m_handle_valid,
    output logic                m_last_result,
    output logic [BATCH_W-1:0]  m_batch_count,
    output logic [COUNT_W-1:0]  m_bin_count,
    // state stores
    output bin_req_t            bin_req,
    input  bin_rsp_t            bin_rsp,
    output link_req_t           link_req,
    input  logic [COUNT_W-1:0]  link_rdata
);

    state_t state_reg, state_next;

    item_t               item_reg;
    logic [HANDLE_W-1:0] cur_reg, cur_next;
    logic [GOT_W-1:0]    got_reg, got_next;
    logic [GOT_W-1:0]    limit_reg, limit_next;
    logic [GOT_W-1:0]    emit_reg, emit_next;
    logic [COUNT_W-1:0]  tally_reg, tally_next;
    logic [HANDLE_W-1:0] pbuf_reg [MAX_BATCH];

    logic                out_valid_reg, out_valid_next;
    logic [HANDLE_W-1:0] out_handle_reg, out_handle_next;
    logic                out_hv_reg, out_hv_next;
    logic                out_last_reg, out_last_next;
    logic [BATCH_W-1:0]  out_batch_reg, out_batch_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                out_load;

    logic                buf_we;

    // decode of the latched request against the bin word
    logic               slot_free;
    logic               bin_ok;
    logic [BIN_W-1:0]   bidx;
    logic [GOT_W-1:0]   want_lim;
    logic               pop_start;
    logic               push_ok;
    logic               chain_ok;
    logic [COUNT_W-1:0] prev_link;
    logic [COUNT_W-1:0] new_tally;
    logic [COUNT_W-1:0] resp_count;

    // link walk decode
    logic [COUNT_W-1:0] pop_nx;
    logic               pop_end;
    logic [GOT_W-1:0]   got_inc;
    logic               pop_cont;
    logic [COUNT_W-1:0] tally_dec;
    logic               emit_last;

    assign slot_free = !out_valid_reg || m_tready;
    assign bin_ok    = bin_sel_ok(item_reg.shard, item_reg.size_class);
    assign bidx      = bin_index(item_reg.shard, item_reg.size_class);
    assign want_lim  = (int'(item_reg.want) > MAX_BATCH) ? GOT_W'(MAX_BATCH)
                                                         : GOT_W'(item_reg.want);
    assign pop_start = bin_ok && (item_reg.op == OP_POP) && bin_rsp.nonempty
                       && (want_lim != '0);
    assign push_ok   = bin_ok && (item_reg.op == OP_PUSH) && handle_ok(item_reg.first_handle);
    assign chain_ok  = bin_ok && (item_reg.op == OP_CHAIN) && (item_reg.chain_len != '0)
                       && handle_ok(item_reg.first_handle)
                       && handle_ok(item_reg.last_handle);
    assign prev_link = bin_rsp.nonempty ? {1'b0, bin_rsp.head} : END_LINK;
    assign new_tally = chain_ok ? add_sat(bin_rsp.tally, item_reg.chain_len)
                                : add_sat(bin_rsp.tally, COUNT_W'(1));
    assign resp_count = (push_ok || chain_ok) ? new_tally
                                              : (bin_ok ? bin_rsp.tally : '0);

    assign pop_nx    = handle_ok(cur_reg) ? link_rdata : END_LINK;
    assign pop_end   = link_end(pop_nx);
    assign got_inc   = GOT_W'(got_reg + 1'b1);
    assign pop_cont  = !pop_end && (got_inc < limit_reg);
    assign tally_dec = (tally_reg != '0) ? COUNT_W'(tally_reg - 1'b1) : '0;
    assign emit_last = (GOT_W'(emit_reg + 1'b1) == got_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_BIN;
                end
            end
            ST_BIN: begin
                if (pop_start) begin
                    state_next = ST_POP;
                end else if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP: begin
                if (!pop_cont) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free && emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // store requests, walk registers and result loading
    always_comb begin
        s_tready   = 1'b0;
        bin_req    = '0;
        link_req   = '0;
        buf_we     = 1'b0;
        cur_next   = cur_reg;
        got_next   = got_reg;
        limit_next = limit_reg;
        emit_next  = emit_reg;
        tally_next = tally_reg;
        out_load        = 1'b0;
        out_handle_next = out_handle_reg;
        out_hv_next     = out_hv_reg;
        out_last_next   = out_last_reg;
        out_batch_next  = out_batch_reg;
        out_count_next  = out_count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready        = 1'b1;
                bin_req.rd_en   = s_tvalid;
                bin_req.rd_addr = bin_index(s_item.shard, s_item.size_class);
            end
            ST_BIN: begin
                if (pop_start) begin
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = LINK_AW'(bin_rsp.head);
                    cur_next   = bin_rsp.head;
                    got_next   = '0;
                    limit_next = want_lim;
                    tally_next = bin_rsp.tally;
                    emit_next  = '0;
                end else if (slot_free) begin
                    // single-result operations commit here
                    case (item_reg.op)
                        OP_PUSH: begin
                            link_req.wr_en   = push_ok;
                            link_req.wr_addr = LINK_AW'(item_reg.first_handle);
                            link_req.wr_data = prev_link;
                        end
                        OP_CHAIN: begin
                            link_req.wr_en   = chain_ok;
                            link_req.wr_addr = LINK_AW'(item_reg.last_handle);
                            link_req.wr_data = prev_link;
                        end
                        OP_LINK: begin
                            link_req.wr_en   = handle_ok(item_reg.first_handle);
                            link_req.wr_addr = LINK_AW'(item_reg.first_handle);
                            link_req.wr_data = item_reg.link_value;
                        end
                        default: begin
                            // pop with nothing to take, count query, unknown codes
                        end
                    endcase
                    bin_req.wr_en       = push_ok || chain_ok;
                    bin_req.wr_addr     = bidx;
                    bin_req.wr_head     = item_reg.first_handle;
                    bin_req.wr_tally    = new_tally;
                    bin_req.wr_nonempty = 1'b1;
                    out_load        = 1'b1;
                    out_handle_next = '0;
                    out_hv_next     = 1'b0;
                    out_last_next   = 1'b1;
                    out_batch_next  = '0;
                    out_count_next  = resp_count;
                end
            end
            ST_POP: begin
                // one handle per cycle; next link address comes from the read data
                buf_we     = 1'b1;
                got_next   = got_inc;
                tally_next = tally_dec;
                if (pop_cont) begin
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = LINK_AW'(pop_nx[HANDLE_W-1:0]);
                    cur_next         = pop_nx[HANDLE_W-1:0];
                end else begin
                    bin_req.wr_en       = 1'b1;
                    bin_req.wr_addr     = bidx;
                    bin_req.wr_head     = pop_end ? '0 : pop_nx[HANDLE_W-1:0];
                    bin_req.wr_tally    = tally_dec;
                    bin_req.wr_nonempty = !pop_end;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_load        = 1'b1;
                    out_handle_next = pbuf_reg[emit_reg[BUF_W-1:0]];
                    out_hv_next     = 1'b1;
                    out_last_next   = emit_last;
                    out_batch_next  = BATCH_W'(emit_reg + 1'b1);
                    out_count_next  = tally_reg;
                    emit_next       = GOT_W'(emit_reg + 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
        if (buf_we) begin
            pbuf_reg[got_reg[BUF_W-1:0]] <= cur_reg;
        end
        cur_reg   <= cur_next;
        got_reg   <= got_next;
        limit_reg <= limit_next;
        emit_reg  <= emit_next;
        tally_reg <= tally_next;
        if (out_load) begin
            out_handle_reg <= out_handle_next;
            out_hv_reg     <= out_hv_next;
            out_last_reg   <= out_last_next;
            out_batch_reg  <= out_batch_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_popped_handle = out_handle_reg;
    assign m_handle_valid  = out_hv_reg;
    assign m_last_result   = out_last_reg;
    assign m_batch_count   = out_batch_reg;
    assign m_bin_count     = out_count_reg;

    // checks
    `SSCFL_ASSERT_IMPL(a_pop_bound, aclk, aresetn, state_reg == ST_POP, got_reg < limit_reg)
    `SSCFL_ASSERT_NEXT(a_emit_done, aclk, aresetn, state_reg == ST_EMIT && emit_last && slot_free, state_reg == ST_IDLE)
    `SSCFL_ASSERT_IMPL(a_bin_wr_busy, aclk, aresetn, bin_req.wr_en, state_reg != ST_IDLE)
    `SSCFL_ASSERT_IMPL(a_handle_batch, aclk, aresetn, out_valid_reg && out_hv_reg, out_batch_reg != '0)

endmodule

// File: rtl/core/sharded_size_class_free_list_pool.sv
// Free-list pool with one LIFO list of handles per (shard, size class) bin.
// Depends on sscfl_pkg, sscfl_bin_table, sscfl_ram and sscfl_seq.
//
// Usage:
//  - s_ channel takes one request per handshake: push one handle, splice a
//    pre-linked chain, pop a batch, query a count, or write a link.
//  - m_ channel returns results: one per popped handle for a pop batch,
//    otherwise one; tlast marks the final result of a request and tuser
//    says that tdata carries a removed handle.
//  - A request other than a pop: the bin word is read from the bin RAM in
//    the accept cycle and updated in ST_BIN once the result slot is free;
//    its result is registered then.
//  - A pop of n handles walks the link RAM at one read per handle, then
//    sends its n results at up to one per cycle as the m_ side allows.
//  - One request is in flight at a time; s_tready is high only between
//    requests. A stalled m_ side holds the result register and the
//    sequencer waits for it.
//  - Reset marks every bin empty with a zero count at once; head and link
//    storage need no clearing, so no request is held off after reset.
module sharded_size_class_free_list_pool
    import sscfl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [2:0] op, [5:3] shard, [9:6] size_class, [21:10] first_handle,
    // [33:22] last_handle, [46:34] chain_len, [52:47] want, [65:53] link_value
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [11:0] popped_handle, [17:12] batch_count, [30:18] bin_count
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] handle_valid
    output logic                 m_tuser,
    output logic                 m_tlast
);

    item_t               s_item;
    bin_req_t            bin_req;
    bin_rsp_t            bin_rsp;
    link_req_t           link_req;
    logic [COUNT_W-1:0]  link_rdata;
    logic [HANDLE_W-1:0] popped_handle;
    logic [BATCH_W-1:0]  batch_count;
    logic [COUNT_W-1:0]  bin_count;

    // request unpacking
    assign s_item.op           = s_tdata[2:0];
    assign s_item.shard        = s_tdata[5:3];
    assign s_item.size_class   = s_tdata[9:6];
    assign s_item.first_handle = s_tdata[21:10];
    assign s_item.last_handle  = s_tdata[33:22];
    assign s_item.chain_len    = s_tdata[46:34];
    assign s_item.want         = s_tdata[52:47];
    assign s_item.link_value   = s_tdata[65:53];

    sscfl_bin_table u_bins (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bin_req),
        .rsp     (bin_rsp)
    );

    // successor per handle
    sscfl_ram #(
        .DEPTH (LINK_DEPTH),
        .WIDTH (COUNT_W)
    ) u_links (
        .aclk  (aclk),
        .we    (link_req.wr_en),
        .waddr (link_req.wr_addr),
        .wdata (link_req.wr_data),
        .re    (link_req.rd_en),
        .raddr (link_req.rd_addr),
        .rdata (link_rdata)
    );

    sscfl_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_item          (s_item),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_popped_handle (popped_handle),
        .m_handle_valid  (m_tuser),
        .m_last_result   (m_tlast),
        .m_batch_count   (batch_count),
        .m_bin_count     (bin_count),
        .bin_req         (bin_req),
        .bin_rsp         (bin_rsp),
        .link_req        (link_req),
        .link_rdata      (link_rdata)
    );

    // result packing
    assign m_tdata = {1'b0, bin_count, batch_count, popped_handle};

endmodule
